[rtl/core/rsa_pkg.sv]
package rsa_pkg;

    // Default table geometry.
    localparam int ROWS_DEFAULT = 1024;
    localparam int VARS_DEFAULT = 16;

    // Field widths of the item and result channels.
    localparam int SAMPLE_W = 32;
    localparam int ROW_W    = 10;
    localparam int VAR_W    = 4;
    localparam int TRIAL_W  = 16;

    // Fixed-point formats: mean is Q32.16, M2 and variance are Q48.16.
    localparam int FRAC_W = 16;
    localparam int MEAN_W = SAMPLE_W + FRAC_W;
    localparam int M2_W   = 64;

    // Divisor n + 1 spans 1 to 65536.
    localparam int DIV_W = TRIAL_W + 1;

    // Product of two mean-width magnitudes and its pipeline depth.
    localparam int PROD_W  = 2 * MEAN_W;
    localparam int MUL_LAT = 2;

    // One table entry as it is stored in the state memory.
    typedef struct packed {
        logic [MEAN_W-1:0]   mean;
        logic [M2_W-1:0]     m2;
        logic [SAMPLE_W-1:0] min_val;
        logic [SAMPLE_W-1:0] max_val;
    } entry_t;

    localparam int ENTRY_W = MEAN_W + M2_W + 2 * SAMPLE_W;

    // Entry value after reset.
    localparam entry_t CLEAR_ENTRY = '{
        mean:    '0,
        m2:      '0,
        min_val: '1,
        max_val: '0
    };

endpackage

[rtl/core/rsa_if.sv]
// Sample channel: one transfer carries one observation.
interface rsa_in_if;
    logic                         valid;
    logic                         ready;
    logic [rsa_pkg::SAMPLE_W-1:0] sample;
    logic [rsa_pkg::ROW_W-1:0]    row;
    logic [rsa_pkg::VAR_W-1:0]    var_index;
    logic [rsa_pkg::TRIAL_W-1:0]  trial;

    modport source (output valid, sample, row, var_index, trial, input ready);
    modport sink (input valid, sample, row, var_index, trial, output ready);
endinterface

// Statistics channel: one transfer carries the updated statistics of one entry.
interface rsa_out_if;
    logic                         valid;
    logic                         ready;
    logic [rsa_pkg::MEAN_W-1:0]   mean_out;
    logic [rsa_pkg::M2_W-1:0]     variance_out;
    logic [rsa_pkg::SAMPLE_W-1:0] min_out;
    logic [rsa_pkg::SAMPLE_W-1:0] max_out;

    modport source (output valid, mean_out, variance_out, min_out, max_out, input ready);
    modport sink (input valid, mean_out, variance_out, min_out, max_out, output ready);
endinterface

[rtl/core/running_stats_accumulator_core.sv]
// Running statistics accumulator: keeps mean, M2, minimum and maximum for each
// (row, variable) entry and applies an online Welford update per sample.
// The samples channel takes one observation per transfer; the stats channel
// returns one transfer per observation, in order, with the updated mean,
// variance (M2 / (n + 1)), minimum and maximum. An item addressing a row or
// variable beyond the table changes nothing and returns all zeros.
// Throughput is one item per cycle while the stats receiver takes results and
// no entry hazard holds the input. A sample whose entry is still being updated
// by an earlier item waits in the input register until that item has written
// back; this read-modify-write window is set by the 48-stage mean divider
// between the memory read and the write. The path from the input transfer to
// a valid result runs through the two bit-per-stage dividers (48 stages for
// the mean, 64 for the variance). After reset the block sweeps the state
// memory, all ROWS * VARS entries (16384 by default), one entry per cycle,
// with samples.ready low. When the stats receiver stalls the whole pipeline
// holds; the input register still takes one more sample.
module running_stats_accumulator_core #(
    parameter int ROWS = rsa_pkg::ROWS_DEFAULT,
    parameter int VARS = rsa_pkg::VARS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    rsa_in_if.sink    samples,
    rsa_out_if.source stats
);

    localparam int DEPTH = ROWS * VARS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TAGS  = 2 + rsa_pkg::MEAN_W + 1 + rsa_pkg::MUL_LAT;

    typedef struct packed {
        logic [rsa_pkg::MEAN_W-1:0]   mean;
        logic                         ge;
        logic [rsa_pkg::MEAN_W-1:0]   dmag;
        logic [rsa_pkg::M2_W-1:0]     m2;
        logic [rsa_pkg::SAMPLE_W-1:0] min_val;
        logic [rsa_pkg::SAMPLE_W-1:0] max_val;
        logic [rsa_pkg::DIV_W-1:0]    d;
        logic                         inr;
        logic [IDX_W-1:0]             idx;
    } mdiv_pay_t;

    typedef struct packed {
        logic [rsa_pkg::MEAN_W-1:0]   mean;
        logic [rsa_pkg::M2_W-1:0]     m2;
        logic [rsa_pkg::SAMPLE_W-1:0] min_val;
        logic [rsa_pkg::SAMPLE_W-1:0] max_val;
        logic [rsa_pkg::DIV_W-1:0]    d;
        logic                         inr;
        logic [IDX_W-1:0]             idx;
    } mul_pay_t;

    typedef struct packed {
        logic [rsa_pkg::MEAN_W-1:0]   mean;
        logic [rsa_pkg::SAMPLE_W-1:0] min_val;
        logic [rsa_pkg::SAMPLE_W-1:0] max_val;
        logic                         inr;
    } vdiv_pay_t;

    // Control signals.
    logic clearing_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic en;
    logic in_ready;
    logic accept;
    logic issue;
    logic hazard;

    // Input register.
    logic                          i_valid_reg;
    logic [rsa_pkg::SAMPLE_W-1:0]  i_sample_reg;
    logic [rsa_pkg::TRIAL_W-1:0]   i_trial_reg;
    logic                          i_inr_reg;
    logic [IDX_W-1:0]              i_idx_reg;
    logic                          in_range;
    logic [31:0]                   idx_full;
    logic [IDX_W-1:0]              in_idx;

    // Outstanding-write tags, one per stage from the read to the write.
    logic             tag_live_reg [TAGS];
    logic [IDX_W-1:0] tag_idx_reg  [TAGS];

    // Memory ports.
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    rsa_pkg::entry_t              ram_wdata;
    logic [rsa_pkg::ENTRY_W-1:0]  ram_rdata;
    rsa_pkg::entry_t              rd_entry;

    // Read stage.
    logic                          s1_valid_reg;
    logic [rsa_pkg::SAMPLE_W-1:0]  s1_sample_reg;
    logic [rsa_pkg::DIV_W-1:0]     s1_d_reg;
    logic                          s1_inr_reg;
    logic [IDX_W-1:0]              s1_idx_reg;

    // Delta stage.
    logic                          s2_valid_reg;
    mdiv_pay_t                     s2_pay_reg;
    mdiv_pay_t                     s2_pay_next;
    logic [rsa_pkg::MEAN_W-1:0]    x_val;

    // Mean divider outputs.
    logic                          mdiv_valid;
    logic [rsa_pkg::MEAN_W-1:0]    mdiv_quot;
    logic [$bits(mdiv_pay_t)-1:0]  mdiv_pay_bits;
    mdiv_pay_t                     mdiv_pay;

    // Mean update stage.
    logic                          f_valid_reg;
    logic [rsa_pkg::MEAN_W-1:0]    f_dmag_reg;
    logic [rsa_pkg::MEAN_W-1:0]    f_rmag_reg;
    mul_pay_t                      f_pay_reg;
    mul_pay_t                      f_pay_next;

    // Multiplier outputs and write-back.
    logic                          mul_valid;
    logic [rsa_pkg::M2_W-1:0]      mul_prod;
    logic [$bits(mul_pay_t)-1:0]   mul_pay_bits;
    mul_pay_t                      mul_pay;
    logic [rsa_pkg::M2_W:0]        sum_raw;
    logic [rsa_pkg::M2_W-1:0]      wb_sum;
    logic                          wb_we;
    logic [IDX_W-1:0]              wb_idx;

    // Write-back stage.
    logic                          w_valid_reg;
    logic [rsa_pkg::M2_W-1:0]      w_sum_reg;
    logic [rsa_pkg::DIV_W-1:0]     w_d_reg;
    vdiv_pay_t                     w_pay_reg;

    // Variance divider outputs.
    logic                          vdiv_valid;
    logic [rsa_pkg::M2_W-1:0]      vdiv_quot;
    logic [$bits(vdiv_pay_t)-1:0]  vdiv_pay_bits;
    vdiv_pay_t                     vdiv_pay;

    // Output register.
    logic                          out_valid_reg;
    logic [rsa_pkg::MEAN_W-1:0]    out_mean_reg;
    logic [rsa_pkg::M2_W-1:0]      out_var_reg;
    logic [rsa_pkg::SAMPLE_W-1:0]  out_min_reg;
    logic [rsa_pkg::SAMPLE_W-1:0]  out_max_reg;

    // Memory clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == IDX_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Pipeline advance and input handshake.
    assign en       = !out_valid_reg || stats.ready;
    assign issue    = i_valid_reg && en && !hazard && !clearing_reg;
    assign in_ready = !clearing_reg && (!i_valid_reg || issue);
    assign accept   = samples.valid && in_ready;
    assign samples.ready = in_ready;

    // Entry address of the incoming sample.
    always_comb
    begin
        in_range = (32'(samples.row) < 32'(ROWS)) && (32'(samples.var_index) < 32'(VARS));
        idx_full = 32'(samples.row) * 32'(VARS) + 32'(samples.var_index);
        in_idx   = in_range ? idx_full[IDX_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            i_valid_reg <= 1'b1;
        end
        else if (issue)
        begin
            i_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_sample_reg <= samples.sample;
            i_trial_reg  <= samples.trial;
            i_inr_reg    <= in_range;
            i_idx_reg    <= in_idx;
        end
    end

    // Interlock: hold the sample while an earlier update of its entry is in flight.
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < TAGS; k++)
        begin
            if (tag_live_reg[k] && (tag_idx_reg[k] == i_idx_reg) && i_inr_reg)
            begin
                hazard = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAGS; k++)
            begin
                tag_live_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            tag_live_reg[0] <= issue && i_inr_reg;
            for (int k = 1; k < TAGS; k++)
            begin
                tag_live_reg[k] <= tag_live_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_idx_reg[0] <= i_idx_reg;
            for (int k = 1; k < TAGS; k++)
            begin
                tag_idx_reg[k] <= tag_idx_reg[k-1];
            end
        end
    end

    // State memory: the clearing sweep or the write-back owns the write port.
    always_comb
    begin
        ram_we    = clearing_reg || wb_we;
        ram_waddr = clearing_reg ? clr_addr_reg : wb_idx;
        if (clearing_reg)
        begin
            ram_wdata = rsa_pkg::CLEAR_ENTRY;
        end
        else
        begin
            ram_wdata.mean    = mul_pay.mean;
            ram_wdata.m2      = wb_sum;
            ram_wdata.min_val = mul_pay.min_val;
            ram_wdata.max_val = mul_pay.max_val;
        end
    end

    rsa_ram #(
        .WIDTH (rsa_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (i_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = rsa_pkg::entry_t'(ram_rdata);

    // Read stage: the item lines up with the memory read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_sample_reg <= i_sample_reg;
            s1_d_reg      <= rsa_pkg::DIV_W'({1'b0, i_trial_reg}) + rsa_pkg::DIV_W'(1);
            s1_inr_reg    <= i_inr_reg;
            s1_idx_reg    <= i_idx_reg;
        end
    end

    // Delta magnitude and sign, new minimum and maximum.
    always_comb
    begin
        x_val               = {s1_sample_reg, rsa_pkg::FRAC_W'(0)};
        s2_pay_next.mean    = rd_entry.mean;
        s2_pay_next.ge      = (x_val >= rd_entry.mean);
        s2_pay_next.dmag    = s2_pay_next.ge ? (x_val - rd_entry.mean) : (rd_entry.mean - x_val);
        s2_pay_next.m2      = rd_entry.m2;
        s2_pay_next.min_val = (s1_sample_reg < rd_entry.min_val) ? s1_sample_reg
                                                                 : rd_entry.min_val;
        s2_pay_next.max_val = (s1_sample_reg > rd_entry.max_val) ? s1_sample_reg
                                                                 : rd_entry.max_val;
        s2_pay_next.d       = s1_d_reg;
        s2_pay_next.inr     = s1_inr_reg;
        s2_pay_next.idx     = s1_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pay_reg <= s2_pay_next;
        end
    end

    // delta / (n + 1).
    rsa_div #(
        .NUM_W (rsa_pkg::MEAN_W),
        .DEN_W (rsa_pkg::DIV_W),
        .PAY_W ($bits(mdiv_pay_t))
    ) u_mean_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .num       (s2_pay_reg.dmag),
        .den       (s2_pay_reg.d),
        .pay_in    (s2_pay_reg),
        .out_valid (mdiv_valid),
        .quot      (mdiv_quot),
        .pay_out   (mdiv_pay_bits)
    );

    assign mdiv_pay = mdiv_pay_t'(mdiv_pay_bits);

    // New mean, and the distance of the sample from it, which is delta less the step.
    always_comb
    begin
        f_pay_next.mean    = mdiv_pay.ge ? (mdiv_pay.mean + mdiv_quot)
                                         : (mdiv_pay.mean - mdiv_quot);
        f_pay_next.m2      = mdiv_pay.m2;
        f_pay_next.min_val = mdiv_pay.min_val;
        f_pay_next.max_val = mdiv_pay.max_val;
        f_pay_next.d       = mdiv_pay.d;
        f_pay_next.inr     = mdiv_pay.inr;
        f_pay_next.idx     = mdiv_pay.idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= mdiv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_dmag_reg <= mdiv_pay.dmag;
            f_rmag_reg <= mdiv_pay.dmag - mdiv_quot;
            f_pay_reg  <= f_pay_next;
        end
    end

    // M2 increment.
    rsa_mul #(
        .PAY_W ($bits(mul_pay_t))
    ) u_m2_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid_reg),
        .a         (f_dmag_reg),
        .b         (f_rmag_reg),
        .pay_in    (f_pay_reg),
        .out_valid (mul_valid),
        .prod      (mul_prod),
        .pay_out   (mul_pay_bits)
    );

    assign mul_pay = mul_pay_t'(mul_pay_bits);

    // Saturating M2 accumulate and write-back.
    always_comb
    begin
        sum_raw = {1'b0, mul_pay.m2} + {1'b0, mul_prod};
        wb_sum  = sum_raw[rsa_pkg::M2_W] ? '1 : sum_raw[rsa_pkg::M2_W-1:0];
        wb_we   = en && mul_valid && mul_pay.inr;
        wb_idx  = mul_pay.idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            w_valid_reg <= mul_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_sum_reg         <= wb_sum;
            w_d_reg           <= mul_pay.d;
            w_pay_reg.mean    <= mul_pay.mean;
            w_pay_reg.min_val <= mul_pay.min_val;
            w_pay_reg.max_val <= mul_pay.max_val;
            w_pay_reg.inr     <= mul_pay.inr;
        end
    end

    // M2 / (n + 1).
    rsa_div #(
        .NUM_W (rsa_pkg::M2_W),
        .DEN_W (rsa_pkg::DIV_W),
        .PAY_W ($bits(vdiv_pay_t))
    ) u_var_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (w_valid_reg),
        .num       (w_sum_reg),
        .den       (w_d_reg),
        .pay_in    (w_pay_reg),
        .out_valid (vdiv_valid),
        .quot      (vdiv_quot),
        .pay_out   (vdiv_pay_bits)
    );

    assign vdiv_pay = vdiv_pay_t'(vdiv_pay_bits);

    // Output register; items outside the table report zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vdiv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_mean_reg <= vdiv_pay.inr ? vdiv_pay.mean : '0;
            out_var_reg  <= vdiv_pay.inr ? vdiv_quot : '0;
            out_min_reg  <= vdiv_pay.inr ? vdiv_pay.min_val : '0;
            out_max_reg  <= vdiv_pay.inr ? vdiv_pay.max_val : '0;
        end
    end

    assign stats.valid        = out_valid_reg;
    assign stats.mean_out     = out_mean_reg;
    assign stats.variance_out = out_var_reg;
    assign stats.min_out      = out_min_reg;
    assign stats.max_out      = out_max_reg;

    // No sample enters while the memory is being cleared.
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !samples.ready)
        else $error("sample accepted during memory clearing");

    // The clearing sweep never competes with a write-back.
    a_clear_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !wb_we)
        else $error("write-back during memory clearing");

    // A read never targets the entry being written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        issue && i_inr_reg && wb_we |-> wb_idx != i_idx_reg)
        else $error("read of an entry with a pending write-back");

    // The sweep ends right after the last entry.
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg && (clr_addr_reg == IDX_W'(DEPTH - 1)) |=> !clearing_reg)
        else $error("memory clearing did not end after the last entry");

endmodule

[rtl/core/rsa_ram.sv]
// Simple dual-port RAM with one write port and a registered read port.
module rsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rsa_div.sv]
// Pipelined restoring divider: one quotient bit per stage, NUM_W stages.
// A payload travels alongside each division.
module rsa_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 17,
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [PAY_W-1:0] pay_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quot,
    output logic [PAY_W-1:0] pay_out
);

    logic             valid_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg   [NUM_W];
    logic [NUM_W-1:0] nq_reg    [NUM_W];
    logic [DEN_W-1:0] den_reg   [NUM_W];
    logic [PAY_W-1:0] pay_reg   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             valid_prev;
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] nq_prev;
        logic [DEN_W-1:0] den_prev;
        logic [PAY_W-1:0] pay_prev;
        logic [DEN_W:0]   shifted;
        logic             take;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        // The first stage takes the dividend with a zero remainder.
        if (k == 0)
        begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = '0;
            assign nq_prev    = num;
            assign den_prev   = den;
            assign pay_prev   = pay_in;
        end
        else
        begin : g_rest
            assign valid_prev = valid_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign nq_prev    = nq_reg[k-1];
            assign den_prev   = den_reg[k-1];
            assign pay_prev   = pay_reg[k-1];
        end

        // Shift in the next dividend bit and subtract the divisor if it fits.
        // Quotient bits enter at the bottom as dividend bits leave the top.
        always_comb
        begin
            shifted  = {rem_prev, nq_prev[NUM_W-1]};
            take     = (shifted >= {1'b0, den_prev});
            rem_next = take ? DEN_W'(shifted - {1'b0, den_prev}) : shifted[DEN_W-1:0];
            nq_next  = {nq_prev[NUM_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= nq_next;
                den_reg[k] <= den_prev;
                pay_reg[k] <= pay_prev;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign quot      = nq_reg[NUM_W-1];
    assign pay_out   = pay_reg[NUM_W-1];

endmodule

[rtl/core/rsa_mul.sv]
// Two-stage multiplier for the M2 increment: partial products, then their sum
// truncated to Q.16 with saturation at the M2 width.
module rsa_mul #(
    parameter int PAY_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [rsa_pkg::MEAN_W-1:0] a,
    input  logic [rsa_pkg::MEAN_W-1:0] b,
    input  logic [PAY_W-1:0]           pay_in,
    output logic                       out_valid,
    output logic [rsa_pkg::M2_W-1:0]   prod,
    output logic [PAY_W-1:0]           pay_out
);

    localparam int LO_W = 32;
    localparam int HI_W = rsa_pkg::MEAN_W - LO_W;
    localparam int SAT_LO = rsa_pkg::M2_W + rsa_pkg::FRAC_W;

    logic                      v1_reg;
    logic [2*LO_W-1:0]         ll_reg;
    logic [LO_W+HI_W-1:0]      lh_reg;
    logic [LO_W+HI_W-1:0]      hl_reg;
    logic [2*HI_W-1:0]         hh_reg;
    logic [PAY_W-1:0]          pay1_reg;

    logic                      v2_reg;
    logic [rsa_pkg::M2_W-1:0]  prod_reg;
    logic [PAY_W-1:0]          pay2_reg;

    logic [rsa_pkg::PROD_W-1:0] full;
    logic [rsa_pkg::M2_W-1:0]   prod_next;

    // Combine the partial products and saturate.
    always_comb
    begin
        full = rsa_pkg::PROD_W'(ll_reg)
             + (rsa_pkg::PROD_W'(lh_reg) << LO_W)
             + (rsa_pkg::PROD_W'(hl_reg) << LO_W)
             + (rsa_pkg::PROD_W'(hh_reg) << (2 * LO_W));
        if (|full[rsa_pkg::PROD_W-1:SAT_LO])
        begin
            prod_next = '1;
        end
        else
        begin
            prod_next = full[SAT_LO-1:rsa_pkg::FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Stage one: four partial products; stage two: sum and saturation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= a[LO_W-1:0] * b[LO_W-1:0];
            lh_reg   <= a[LO_W-1:0] * b[rsa_pkg::MEAN_W-1:LO_W];
            hl_reg   <= a[rsa_pkg::MEAN_W-1:LO_W] * b[LO_W-1:0];
            hh_reg   <= a[rsa_pkg::MEAN_W-1:LO_W] * b[rsa_pkg::MEAN_W-1:LO_W];
            pay1_reg <= pay_in;
            prod_reg <= prod_next;
            pay2_reg <= pay1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign prod      = prod_reg;
    assign pay_out   = pay2_reg;

endmodule

[tb/sv/running_stats_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the statistics table and
// compares every stats transfer with the oldest predicted result.
module running_stats_checker
(
    input  logic clk,
    input  logic rst_n,
    rsa_in_if    samples,
    rsa_out_if   stats,
    output int   failures,
    output int   pending
);

    localparam int SAMPLE_W = rsa_pkg::SAMPLE_W;
    localparam int ROW_W    = rsa_pkg::ROW_W;
    localparam int VAR_W    = rsa_pkg::VAR_W;
    localparam int TRIAL_W  = rsa_pkg::TRIAL_W;
    localparam int FRAC_W   = rsa_pkg::FRAC_W;
    localparam int MEAN_W   = rsa_pkg::MEAN_W;
    localparam int M2_W     = rsa_pkg::M2_W;
    localparam int DIV_W    = rsa_pkg::DIV_W;
    localparam int PROD_W   = rsa_pkg::PROD_W;

    localparam int NUM_ROWS = rsa_pkg::ROWS_DEFAULT;
    localparam int NUM_VARS = rsa_pkg::VARS_DEFAULT;
    localparam int ENTRIES  = NUM_ROWS * NUM_VARS;

    typedef struct {
        logic [MEAN_W-1:0]   mean;
        logic [M2_W-1:0]     variance;
        logic [SAMPLE_W-1:0] min_val;
        logic [SAMPLE_W-1:0] max_val;
    } stats_t;

    logic [MEAN_W-1:0]   mean_tab [ENTRIES];
    logic [M2_W-1:0]     m2_tab   [ENTRIES];
    logic [SAMPLE_W-1:0] min_tab  [ENTRIES];
    logic [SAMPLE_W-1:0] max_tab  [ENTRIES];

    stats_t expected_stats [$];

    // Welford step on the addressed entry; returns the statistics after it.
    function automatic stats_t welford_update(logic [SAMPLE_W-1:0] sample,
                                              logic [ROW_W-1:0] row,
                                              logic [VAR_W-1:0] vidx,
                                              logic [TRIAL_W-1:0] trial);
        stats_t              res;
        int                  idx;
        logic [MEAN_W-1:0]   x;
        logic [MEAN_W-1:0]   m;
        logic [MEAN_W-1:0]   mnew;
        logic [MEAN_W-1:0]   dmag;
        logic [MEAN_W-1:0]   rmag;
        logic [DIV_W-1:0]    div;
        logic [PROD_W-1:0]   prod;
        logic [M2_W-1:0]     inc;
        logic [M2_W:0]       sum;
        logic [M2_W-1:0]     m2n;
        res = '{default: '0};
        if (row >= NUM_ROWS || vidx >= NUM_VARS)
            return res;
        idx = int'(row) * NUM_VARS + int'(vidx);
        x = {sample, {FRAC_W{1'b0}}};
        m = mean_tab[idx];
        div = DIV_W'(trial) + 1'b1;
        // The mean step is truncated toward the old mean.
        if (x >= m)
        begin
            dmag = x - m;
            mnew = m + MEAN_W'(dmag / div);
            rmag = x - mnew;
        end
        else
        begin
            dmag = m - x;
            mnew = m - MEAN_W'(dmag / div);
            rmag = mnew - x;
        end
        prod = PROD_W'(dmag) * PROD_W'(rmag);
        if (prod[PROD_W-1:M2_W+FRAC_W] != '0)
            inc = '1;
        else
            inc = prod[M2_W+FRAC_W-1:FRAC_W];
        // M2 saturates instead of wrapping.
        sum = {1'b0, m2_tab[idx]} + {1'b0, inc};
        m2n = sum[M2_W] ? '1 : sum[M2_W-1:0];
        mean_tab[idx] = mnew;
        m2_tab[idx] = m2n;
        if (sample < min_tab[idx])
            min_tab[idx] = sample;
        if (sample > max_tab[idx])
            max_tab[idx] = sample;
        res.mean = mnew;
        res.variance = M2_W'(m2n / div);
        res.min_val = min_tab[idx];
        res.max_val = max_tab[idx];
        return res;
    endfunction

    // Predict on each sample transfer and check each stats transfer.
    always @(posedge clk or negedge rst_n)
    begin
        stats_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                mean_tab[i] = '0;
                m2_tab[i] = '0;
                min_tab[i] = '1;
                max_tab[i] = '0;
            end
            expected_stats.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (stats.valid && stats.ready)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("stats transfer with no result expected");
                    failures++;
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (stats.mean_out !== want.mean)
                    begin
                        $error("mean_out: expected %0h, got %0h", want.mean, stats.mean_out);
                        failures++;
                    end
                    if (stats.variance_out !== want.variance)
                    begin
                        $error("variance_out: expected %0h, got %0h",
                               want.variance, stats.variance_out);
                        failures++;
                    end
                    if (stats.min_out !== want.min_val)
                    begin
                        $error("min_out: expected %0h, got %0h", want.min_val, stats.min_out);
                        failures++;
                    end
                    if (stats.max_out !== want.max_val)
                    begin
                        $error("max_out: expected %0h, got %0h", want.max_val, stats.max_out);
                        failures++;
                    end
                end
            end
            if (samples.valid && samples.ready)
                expected_stats.insert(expected_stats.size(),
                                      welford_update(samples.sample, samples.row,
                                                     samples.var_index, samples.trial));
            pending = expected_stats.size();
        end
    end

endmodule

[tb/sv/running_stats_accumulator_core_test.sv]
`timescale 1ns / 1ps

// Drives samples and stalls into the accumulator and gives the verdict.
module running_stats_accumulator_core_test;

    localparam int SAMPLE_W     = rsa_pkg::SAMPLE_W;
    localparam int ROW_W        = rsa_pkg::ROW_W;
    localparam int VAR_W        = rsa_pkg::VAR_W;
    localparam int TRIAL_W      = rsa_pkg::TRIAL_W;
    localparam int VARS_DEFAULT = rsa_pkg::VARS_DEFAULT;

    localparam int NUM_ITEMS  = 900;
    localparam int CALM_ITEMS = 150;
    localparam int IDLE_LIMIT = 60000;
    localparam int POOL       = 6;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   idle_cycles;
    bit   calm;

    // Per-entry update count, used as the trial number of well-formed sequences.
    int   trial_count [int];
    int   pool_row [POOL];
    int   pool_var [POOL];

    rsa_in_if  in_ch ();
    rsa_out_if out_ch ();

    running_stats_accumulator_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch),
        .stats   (out_ch)
    );

    running_stats_checker checker_i
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (in_ch),
        .stats    (out_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Offers one sample and holds it until the transfer happens.
    task automatic send_sample(logic [SAMPLE_W-1:0] s, int r, int v, logic [TRIAL_W-1:0] t);
        in_ch.valid <= 1'b1;
        in_ch.sample <= s;
        in_ch.row <= ROW_W'(r);
        in_ch.var_index <= VAR_W'(v);
        in_ch.trial <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Sends the next sample of an entry's sequence with a matching trial number.
    task automatic send_next(logic [SAMPLE_W-1:0] s, int r, int v);
        int key;
        key = r * VARS_DEFAULT + v;
        if (!trial_count.exists(key))
            trial_count[key] = 0;
        send_sample(s, r, v, TRIAL_W'(trial_count[key] > 65535 ? 65535 : trial_count[key]));
        trial_count[key]++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] base);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            default: return base + $urandom_range(0, 64) - 32;
        endcase
    endfunction

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Receiver stalls come in random bursts, except during the calm tail.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Watchdog on cycles without any transfer; allows for the clearing sweep.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[running_stats_accumulator_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0] base;
        int p;
        idle_cycles = 0;
        calm = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.row = '0;
        in_ch.var_index = '0;
        in_ch.trial = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, first update, trial mismatch, saturation of M2.
        send_next('0, 0, 0);
        send_next('1, 0, 0);
        send_next('1, 1023, 15);
        send_next('0, 1023, 15);
        send_sample(32'h0000_1234, 5, 3, '1);
        send_sample(32'h8000_0000, 5, 3, '0);
        send_sample(32'h0000_0001, 700, 9, 16'h0001);
        send_sample(32'hFFFF_FFFE, 341, 10, 16'h8000);
        for (int i = 0; i < 8; i++)
            send_next(i[0] ? '1 : '0, 2, 7);
        for (int i = 0; i < 4; i++)
            send_next(32'd100, 3, 1);
        send_sample(32'h5555_5555, 682, 5, 16'h5555);
        send_sample(32'hAAAA_AAAA, 341, 10, 16'hAAAA);
        in_ch.valid <= 1'b0;

        // Let the pipeline drain completely before the random part.
        while (pending != 0)
            @(posedge clk);

        for (int n = 0; n < NUM_ITEMS; n++)
        begin
            if (n == NUM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (n % 120 == 0)
            begin
                for (int k = 0; k < POOL; k++)
                begin
                    pool_row[k] = $urandom_range(0, 1023);
                    pool_var[k] = $urandom_range(0, 15);
                end
                base = $urandom();
                if ($urandom_range(0, 1))
                    base = base >> $urandom_range(0, 31);
            end
            if ($urandom_range(0, 9) == 0)
                send_sample($urandom(), $urandom_range(0, 1023), $urandom_range(0, 15),
                            TRIAL_W'($urandom()));
            else
            begin
                p = $urandom_range(0, POOL - 1);
                send_next(pick_sample(base), pool_row[p], pool_var[p]);
            end
            sender_gap();
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        if (failures == 0)
            $display("[running_stats_accumulator_core] OK");
        else
            $display("[running_stats_accumulator_core] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rsa_pkg.sv
rtl/core/rsa_if.sv
rtl/core/rsa_ram.sv
rtl/core/rsa_div.sv
rtl/core/rsa_mul.sv
rtl/core/running_stats_accumulator_core.sv
tb/sv/running_stats_checker.sv
tb/sv/running_stats_accumulator_core_test.sv
